/* design/utf16_to_utf8_transcoder_macros.svh */
// ----------------------------------------------------------------------------
// UTF-16/UTF-32 to UTF-8 transcoder assertion macros
// Shared wrappers for concurrent assertions clocked on clock, held off in reset.
// ----------------------------------------------------------------------------
`ifndef UTF16_TO_UTF8_TRANSCODER_MACROS_SVH
`define UTF16_TO_UTF8_TRANSCODER_MACROS_SVH

// Same-cycle implication.
`define UTT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define UTT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/utt_pkg.sv */
// ----------------------------------------------------------------------------
// UTF-16/UTF-32 to UTF-8 transcoder package
// Job type passed from the classifier to the byte emitter, code point
// constants and the UTF-8 byte helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package utt_pkg;

   localparam int CP_W = 21;

   localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;
   localparam logic [CP_W-1:0] CP_SUPP_BASE   = 21'h010000;
   localparam logic [31:0]     CP_MAX         = 32'h0010FFFF;
   localparam logic [31:0]     SURR_FIRST     = 32'h0000D800;
   localparam logic [31:0]     SURR_LAST      = 32'h0000DFFF;
   localparam logic [15:0]     HIGH_FIRST     = 16'hD800;
   localparam logic [15:0]     HIGH_LAST      = 16'hDBFF;
   localparam logic [15:0]     LOW_FIRST      = 16'hDC00;
   localparam logic [15:0]     LOW_LAST       = 16'hDFFF;

   // One queued job: an optional U+FFFD for a dropped high surrogate,
   // then an optional code point, both already checked for validity.
   typedef struct packed {
      logic            pre_fffd;
      logic            has_cp;
      logic [CP_W-1:0] cp;
      logic            eos;
   } utt_job_type;

   // Replace surrogates and out-of-range values by U+FFFD.
   function automatic logic [CP_W-1:0] utt_sanitize(input logic [31:0] value);
      logic bad;
      bad = (value > CP_MAX) || ((value >= SURR_FIRST) && (value <= SURR_LAST));
      return bad ? CP_REPLACEMENT : value[CP_W-1:0];
   endfunction

   // Index of the final UTF-8 byte of a valid code point (length minus one).
   function automatic logic [1:0] utt_last_index(input logic [CP_W-1:0] cp);
      logic [1:0] idx;
      if (cp < 21'h000080) begin
         idx = 2'd0;
      end else if (cp < 21'h000800) begin
         idx = 2'd1;
      end else if (cp < 21'h010000) begin
         idx = 2'd2;
      end else begin
         idx = 2'd3;
      end
      return idx;
   endfunction

   // UTF-8 byte number idx of a valid code point.
   function automatic logic [7:0] utt_byte(input logic [CP_W-1:0] cp,
                                           input logic [1:0]      idx);
      logic [1:0] last;
      logic [7:0] b;
      last = utt_last_index(cp);
      b    = 8'h00;
      case (last)
         2'd0: b = {1'b0, cp[6:0]};
         2'd1: begin
            case (idx)
               2'd0:    b = {3'b110, cp[10:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         2'd2: begin
            case (idx)
               2'd0:    b = {4'b1110, cp[15:12]};
               2'd1:    b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         default: begin
            case (idx)
               2'd0:    b = {5'b11110, cp[20:18]};
               2'd1:    b = {2'b10, cp[17:12]};
               2'd2:    b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

/* design/utf16_to_utf8_transcoder.sv */
// The first UTF-8 byte of an item passes the job queue, the emitter's job register and the output register.
// The emitter delivers one byte per cycle unless rsp_tready stalls the output;
// a high surrogate that is held produces no byte and queues no job of its own.
// The job queue lets items enter while earlier bytes are still being delivered.
// Reset (synchronous, active high) clears the mode to UTF-16, drops any held
// surrogate and empties the queue and the output register.
// ----------------------------------------------------------------------------
// UTF-16/UTF-32 to UTF-8 transcoder
// Converts a stream of UTF-16 code units or UTF-32 code points to UTF-8 bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module utf16_to_utf8_transcoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Mode register write channel.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_data,      // [0] wide_units_mode
   // Input items.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,     // [31:0] code_unit
   input  wire logic        req_tlast,     // end_of_string
   // Result items.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,     // [7:0] utf8_byte
   output logic             rsp_tlast,     // last_of_run
   output logic             rsp_tuser      // [0] string_done
);
   import utt_pkg::*;

   logic        wide_mode_ff;
   logic        accept;
   logic        push, pop, full, not_empty;
   utt_job_type push_job, pop_job;

   // Mode register.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_mode_ff <= 1'b0;
      end else if (csr_valid) begin
         wide_mode_ff <= csr_data;
      end
   end

   assign req_tready = !full;
   assign accept     = req_tvalid && !full;

   utt_front u_front (
      .clock         (clock),
      .reset         (reset),
      .wide_mode     (wide_mode_ff),
      .accept        (accept),
      .code_unit     (req_tdata),
      .end_of_string (req_tlast),
      .push          (push),
      .push_job      (push_job)
   );

   utt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_job   (pop_job)
   );

   utt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (not_empty),
      .job        (pop_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

/* design/utt_front.sv */
// ----------------------------------------------------------------------------
// UTF-16/UTF-32 to UTF-8 transcoder front end
// Accepts code units, tracks a pending high surrogate and turns each item
// into at most one queued job.
// ----------------------------------------------------------------------------
`default_nettype none

module utt_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               wide_mode,
   input  wire logic               accept,
   input  wire logic [31:0]        code_unit,
   input  wire logic               end_of_string,
   output logic                    push,
   output utt_pkg::utt_job_type    push_job
);
   import utt_pkg::*;

   logic        held_valid_ff, held_valid_in;
   logic [9:0]  held_bits_ff, held_bits_in;
   logic [15:0] unit16;
   logic        is_high, is_low;
   utt_job_type job;

   assign unit16  = code_unit[15:0];
   assign is_high = (unit16 >= HIGH_FIRST) && (unit16 <= HIGH_LAST);
   assign is_low  = (unit16 >= LOW_FIRST) && (unit16 <= LOW_LAST);

   // Classify the incoming unit against the held surrogate.
   always_comb begin
      job.pre_fffd  = 1'b0;
      job.has_cp    = 1'b1;
      job.cp        = utt_sanitize(code_unit);
      job.eos       = end_of_string;
      held_valid_in = held_valid_ff;
      held_bits_in  = held_bits_ff;
      if (accept) begin
         held_valid_in = 1'b0;
         held_bits_in  = 10'd0;
         if (!wide_mode) begin
            if (held_valid_ff && is_low) begin
               job.cp = CP_SUPP_BASE + {1'b0, held_bits_ff, unit16[9:0]};
            end else begin
               job.pre_fffd = held_valid_ff;
               job.cp       = utt_sanitize({16'h0000, unit16});
               if (is_high && !end_of_string) begin
                  job.has_cp    = 1'b0;
                  held_valid_in = 1'b1;
                  held_bits_in  = unit16[9:0];
               end
            end
         end
      end
   end

   assign push     = accept && (job.pre_fffd || job.has_cp);
   assign push_job = job;

   // Held surrogate state.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         held_bits_ff  <= 10'd0;
      end else begin
         held_valid_ff <= held_valid_in;
         held_bits_ff  <= held_bits_in;
      end
   end

endmodule

`default_nettype wire

/* design/utt_queue.sv */
// ----------------------------------------------------------------------------
// UTF-16/UTF-32 to UTF-8 transcoder job queue
// Small FIFO that decouples the front end from the byte emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module utt_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire utt_pkg::utt_job_type push_job,
   output logic                      full,
   input  wire logic                 pop,
   output logic                      not_empty,
   output utt_pkg::utt_job_type      pop_job
);
   import utt_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   utt_job_type             slot_ff [DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_job   = slot_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

/* design/utt_back.sv */
// ----------------------------------------------------------------------------
// UTF-16/UTF-32 to UTF-8 transcoder byte emitter
// Walks one job at a time and places one UTF-8 byte per cycle in the
// output register while the output is not stalled by rsp_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module utt_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 job_valid,
   input  wire utt_pkg::utt_job_type job,
   output logic                      pop,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [7:0]                rsp_tdata,
   output logic                      rsp_tlast,
   output logic                      rsp_tuser
);
   import utt_pkg::*;

   logic            active_ff, active_in;
   logic            pre_ff, pre_in;
   logic [1:0]      idx_ff, idx_in;
   utt_job_type     job_ff, job_in;
   logic            out_valid_ff, out_valid_in;
   logic [7:0]      out_byte_ff, out_byte_in;
   logic            out_last_ff, out_last_in;
   logic            out_done_ff, out_done_in;

   logic [CP_W-1:0] cur_cp;
   logic [1:0]      cur_last;
   logic [7:0]      cur_byte;
   logic            seg_end, job_end, advance;

   // Current byte of the active job.
   assign cur_cp   = pre_ff ? CP_REPLACEMENT : job_ff.cp;
   assign cur_last = utt_last_index(cur_cp);
   assign cur_byte = utt_byte(cur_cp, idx_ff);
   assign seg_end  = (idx_ff == cur_last);
   assign job_end  = seg_end && (!pre_ff || !job_ff.has_cp);
   assign advance  = active_ff && (!out_valid_ff || rsp_tready);
   assign pop      = job_valid && (!active_ff || (advance && job_end));

   // Job sequencing.
   always_comb begin
      active_in = active_ff;
      pre_in    = pre_ff;
      idx_in    = idx_ff;
      job_in    = job_ff;
      if (pop) begin
         active_in = 1'b1;
         job_in    = job;
         pre_in    = job.pre_fffd;
         idx_in    = 2'd0;
      end else if (advance && job_end) begin
         active_in = 1'b0;
      end else if (advance && seg_end) begin
         pre_in = 1'b0;
         idx_in = 2'd0;
      end else if (advance) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   // Output register.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_done_in  = out_done_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_byte_in  = cur_byte;
         out_last_in  = job_end;
         out_done_in  = job_end && job_ff.eos;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         pre_ff       <= 1'b0;
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         pre_ff       <= pre_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_done_ff <= out_done_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_done_ff;

endmodule

`default_nettype wire

/* design/utt_checker.sv */
// ----------------------------------------------------------------------------
// UTF-16/UTF-32 to UTF-8 transcoder port checker
// Watches the top-level ports and flags behavior the transcoder must not show.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf16_to_utf8_transcoder_macros.svh"

module utt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic        rsp_tuser
);

   // A stalled result item keeps its contents.
   `UTT_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser), "stalled rsp item changed")

   // The end of a string is always the end of an item's run.
   `UTT_ASSERT_NOW(a_done_is_last, rsp_tvalid && rsp_tuser, rsp_tlast, "string_done without last_of_run")

   // Bytes of one run follow each other without gaps.
   `UTT_ASSERT_NEXT(a_run_contiguous, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid, "gap inside a run of bytes")

   // A byte that is not the end of a run is never a continuation-free ASCII byte.
   `UTT_ASSERT_NOW(a_ascii_alone, rsp_tvalid && !rsp_tlast, rsp_tdata[7], "ASCII byte inside a multi-byte run")

endmodule

bind utf16_to_utf8_transcoder utt_checker u_utt_checker (.*);

`default_nettype wire
